[design/weighted_row_mix_normalizer_unit_assert.svh]
// assertion macros for the weighted row mix normalizer
// expects clk and arst_n in the scope where they are used
`ifndef WEIGHTED_ROW_MIX_NORMALIZER_UNIT_ASSERT_SVH
`define WEIGHTED_ROW_MIX_NORMALIZER_UNIT_ASSERT_SVH
// same-cycle implication
`define WRMN_ASSERT_NOW(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define WRMN_ASSERT_NEXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`endif

[design/wrmn_pkg.sv]
// shared constants, types and helpers of the weighted row mix normalizer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package wrmn_pkg;
	localparam int COLUMNS       = 8;
	localparam int ROWS          = 1024;
	localparam int FRACTION_BITS = 15;
	localparam int COL_W   = $clog2(COLUMNS);
	localparam int ROW_W   = $clog2(ROWS);
	localparam int ADDR_W  = ROW_W + COL_W;
	localparam int DEPTH   = ROWS * COLUMNS;
	localparam int PROD_W  = 48;
	localparam int SUM_W   = PROD_W + 1;
	localparam int TOT_W   = SUM_W + COL_W;
	localparam int QW      = FRACTION_BITS + 1;
	localparam int T2_W    = QW + COL_W;
	localparam int STEPS   = FRACTION_BITS + 1;
	localparam int STEP_W  = $clog2(STEPS);
	localparam logic [15:0] FLOOR_RESET = 16'd655;

	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_READ  = 2'd1;
	localparam logic [1:0] MODE_MIX   = 2'd2;
	localparam logic [1:0] MODE_RSVD  = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE, ST_RD, ST_MT, ST_MS, ST_MM, ST_MA,
		ST_P1R, ST_P1S, ST_P1W, ST_P2S, ST_P2W, ST_EM
	} st_t;

	typedef struct packed {
		logic             start;
		logic [TOT_W-1:0] num;
		logic [TOT_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic          busy;
		logic          done;
		logic [QW-1:0] q;
	} div_rsp_t;

	function automatic logic [ADDR_W-1:0] entry_addr(input logic [9:0] row,
		input logic [COL_W-1:0] col);
		entry_addr = {ROW_W'(row), col};
	endfunction

	function automatic logic [15:0] frac_sat(input logic [QW-1:0] v);
		frac_sat = (32'(v) > 32'd65535) ? 16'hFFFF : 16'(v);
	endfunction
endpackage
`default_nettype wire

[design/weighted_row_mix_normalizer_unit.sv]
// Weighted row mix normalizer: element write and read on a row table, and
// a row mix with two normalizing divisions per column on one serial divider.
// Write stores the element on acceptance; read registers the stored word and loads it
// into the output register once the output slot is free. Mix takes one item at a time:
// per column it reads target and source words and weights them, then runs two division
// passes (16-step divider) and emits each column in turn. After reset the row store is zeroed.
`timescale 1ns / 1ps
`default_nettype none
`include "weighted_row_mix_normalizer_unit_assert.svh"
module weighted_row_mix_normalizer_unit (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [15:0]  cfg_wdata,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// target_row[9:0], source_row[19:10], column[22:20], element_value[38:23],
	// target_weight[70:39], amount[102:71], zero pad
	input  wire logic [103:0] s_tdata,
	// mode[1:0]
	input  wire logic [1:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// out_column[2:0], fraction[18:3], degenerate[19], zero pad
	output logic [23:0]       m_tdata,
	output logic              m_tlast
);
	localparam int C_W = wrmn_pkg::COL_W;
	localparam logic [C_W-1:0] LAST_COL = C_W'(wrmn_pkg::COLUMNS - 1);

	wrmn_pkg::st_t state_q, state_d;
	logic [15:0] floor_q;

	// captured item fields
	logic [9:0]  trow_q, srow_q;
	logic [2:0]  col_q;
	logic [31:0] pb_q, amt_q;
	logic        tok_q, sok_q, cok_q;

	logic [C_W-1:0]                j_q;
	logic [wrmn_pkg::PROD_W-1:0]   prod_t_s1, prod_t_s2, prod_s_s2;
	logic [wrmn_pkg::TOT_W-1:0]    total_q;
	logic [wrmn_pkg::T2_W-1:0]     total2_q;
	logic                          deg_q;
	logic [wrmn_pkg::QW-1:0]       frac_q [wrmn_pkg::COLUMNS];
	logic [wrmn_pkg::SUM_W-1:0]    scr_mem [wrmn_pkg::COLUMNS];
	logic [wrmn_pkg::SUM_W-1:0]    scr_rd_q;

	// output register
	logic        m_valid_q;
	logic [2:0]  ocol_q;
	logic [15:0] ofrac_q;
	logic        odeg_q, olast_q;

	// memory and divider hookup
	logic                        ram_we, ram_re, clearing;
	logic [wrmn_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [15:0]                 ram_wdata, ram_rdata;
	wrmn_pkg::div_req_t          dreq;
	wrmn_pkg::div_rsp_t          drsp;

	// input unpacking
	logic        acc;
	logic [9:0]  in_trow, in_srow;
	logic [2:0]  in_col;
	logic [15:0] in_val;
	logic        slot_free;
	logic [wrmn_pkg::SUM_W-1:0] mix_sum;
	logic [wrmn_pkg::QW-1:0]    fl_frac;
	logic [15:0]                em_frac;

	assign in_trow   = s_tdata[9:0];
	assign in_srow   = s_tdata[19:10];
	assign in_col    = s_tdata[22:20];
	assign in_val    = s_tdata[38:23];
	assign s_tready  = (state_q == wrmn_pkg::ST_IDLE) && !clearing;
	assign acc       = s_tvalid && s_tready;
	assign slot_free = !m_valid_q || m_tready;
	assign mix_sum   = wrmn_pkg::SUM_W'(prod_t_s2) + wrmn_pkg::SUM_W'(prod_s_s2);
	assign fl_frac   = (drsp.q < wrmn_pkg::QW'(floor_q)) ? '0 : drsp.q;
	assign em_frac   = deg_q ? 16'd0 : wrmn_pkg::frac_sat(frac_q[j_q]);

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {4'd0, odeg_q, ofrac_q, ocol_q};
	assign m_tlast  = olast_q;

	wrmn_row_ram u_ram (
		.clk      (clk),
		.arst_n   (arst_n),
		.we       (ram_we),
		.waddr    (ram_waddr),
		.wdata    (ram_wdata),
		.re       (ram_re),
		.raddr    (ram_raddr),
		.rdata    (ram_rdata),
		.clearing (clearing)
	);

	wrmn_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	// next state, memory and divider control
	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = wrmn_pkg::entry_addr(in_trow, C_W'(in_col));
		ram_wdata = in_val;
		ram_re    = 1'b0;
		ram_raddr = wrmn_pkg::entry_addr(in_trow, C_W'(in_col));
		dreq      = '0;
		case (state_q)
			wrmn_pkg::ST_IDLE: begin
				if (acc) begin
					case (s_tuser)
						wrmn_pkg::MODE_WRITE: begin
							ram_we = (32'(in_trow) < wrmn_pkg::ROWS)
								&& (32'(in_col) < wrmn_pkg::COLUMNS);
						end
						wrmn_pkg::MODE_READ: begin
							ram_re  = 1'b1;
							state_d = wrmn_pkg::ST_RD;
						end
						wrmn_pkg::MODE_MIX: state_d = wrmn_pkg::ST_MT;
						default: state_d = wrmn_pkg::ST_IDLE;
					endcase
				end
			end
			wrmn_pkg::ST_RD: begin
				if (slot_free) state_d = wrmn_pkg::ST_IDLE;
			end
			wrmn_pkg::ST_MT: begin
				ram_re    = 1'b1;
				ram_raddr = wrmn_pkg::entry_addr(trow_q, j_q);
				state_d   = wrmn_pkg::ST_MS;
			end
			wrmn_pkg::ST_MS: begin
				ram_re    = 1'b1;
				ram_raddr = wrmn_pkg::entry_addr(srow_q, j_q);
				state_d   = wrmn_pkg::ST_MM;
			end
			wrmn_pkg::ST_MM: state_d = wrmn_pkg::ST_MA;
			wrmn_pkg::ST_MA: begin
				state_d = (j_q == LAST_COL) ? wrmn_pkg::ST_P1R : wrmn_pkg::ST_MT;
			end
			wrmn_pkg::ST_P1R: begin
				state_d = (total_q == '0) ? wrmn_pkg::ST_EM : wrmn_pkg::ST_P1S;
			end
			wrmn_pkg::ST_P1S: begin
				dreq.start = 1'b1;
				dreq.num   = wrmn_pkg::TOT_W'(scr_rd_q);
				dreq.den   = total_q;
				state_d    = wrmn_pkg::ST_P1W;
			end
			wrmn_pkg::ST_P1W: begin
				if (drsp.done) begin
					state_d = (j_q == LAST_COL) ? wrmn_pkg::ST_P2S : wrmn_pkg::ST_P1R;
				end
			end
			wrmn_pkg::ST_P2S: begin
				if (total2_q == '0) begin
					state_d = wrmn_pkg::ST_EM;
				end else begin
					dreq.start = 1'b1;
					dreq.num   = wrmn_pkg::TOT_W'(frac_q[j_q]);
					dreq.den   = wrmn_pkg::TOT_W'(total2_q);
					state_d    = wrmn_pkg::ST_P2W;
				end
			end
			wrmn_pkg::ST_P2W: begin
				if (drsp.done) begin
					state_d = (j_q == LAST_COL) ? wrmn_pkg::ST_EM : wrmn_pkg::ST_P2S;
				end
			end
			wrmn_pkg::ST_EM: begin
				if (slot_free) begin
					ram_we    = tok_q;
					ram_waddr = wrmn_pkg::entry_addr(trow_q, j_q);
					ram_wdata = em_frac;
					if (j_q == LAST_COL) state_d = wrmn_pkg::ST_IDLE;
				end
			end
			default: state_d = wrmn_pkg::ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= wrmn_pkg::ST_IDLE;
			floor_q   <= wrmn_pkg::FLOOR_RESET;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) floor_q <= cfg_wdata;
			if ((state_q == wrmn_pkg::ST_RD || state_q == wrmn_pkg::ST_EM) && slot_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (acc) begin
			trow_q <= in_trow;
			srow_q <= in_srow;
			col_q  <= in_col;
			pb_q   <= s_tdata[70:39];
			amt_q  <= s_tdata[102:71];
			tok_q  <= 32'(in_trow) < wrmn_pkg::ROWS;
			sok_q  <= 32'(in_srow) < wrmn_pkg::ROWS;
			cok_q  <= 32'(in_col) < wrmn_pkg::COLUMNS;
			j_q    <= '0;
			deg_q  <= 1'b0;
			total_q  <= '0;
			total2_q <= '0;
		end
		case (state_q)
			wrmn_pkg::ST_RD: begin
				if (slot_free) begin
					ocol_q  <= col_q;
					ofrac_q <= (tok_q && cok_q) ? ram_rdata : 16'd0;
					odeg_q  <= 1'b0;
					olast_q <= 1'b1;
				end
			end
			// target word lands here
			wrmn_pkg::ST_MS: begin
				prod_t_s1 <= wrmn_pkg::PROD_W'(tok_q ? ram_rdata : 16'd0)
					* wrmn_pkg::PROD_W'(pb_q);
			end
			// source word lands here
			wrmn_pkg::ST_MM: begin
				prod_t_s2 <= prod_t_s1;
				prod_s_s2 <= wrmn_pkg::PROD_W'(sok_q ? ram_rdata : 16'd0)
					* wrmn_pkg::PROD_W'(amt_q);
			end
			// weighted sum of this column into scratch and running total
			wrmn_pkg::ST_MA: begin
				scr_mem[j_q] <= mix_sum;
				total_q      <= total_q + wrmn_pkg::TOT_W'(mix_sum);
				j_q          <= j_q + 1'b1;
			end
			wrmn_pkg::ST_P1R: begin
				if (total_q != '0) scr_rd_q <= scr_mem[j_q];
				else deg_q <= 1'b1;
			end
			wrmn_pkg::ST_P1W: begin
				if (drsp.done) begin
					frac_q[j_q] <= fl_frac;
					total2_q    <= total2_q + wrmn_pkg::T2_W'(fl_frac);
					j_q         <= j_q + 1'b1;
				end
			end
			wrmn_pkg::ST_P2S: begin
				if (total2_q == '0) deg_q <= 1'b1;
			end
			wrmn_pkg::ST_P2W: begin
				if (drsp.done) begin
					frac_q[j_q] <= drsp.q;
					j_q         <= j_q + 1'b1;
				end
			end
			wrmn_pkg::ST_EM: begin
				if (slot_free) begin
					ocol_q  <= 3'(j_q);
					ofrac_q <= em_frac;
					odeg_q  <= deg_q;
					olast_q <= j_q == LAST_COL;
					j_q     <= j_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	`WRMN_ASSERT_NOW(a_no_take_busy, acc, !drsp.busy, "item taken while divider busy")
	`WRMN_ASSERT_NOW(a_deg_zero, m_tvalid && m_tdata[19], m_tdata[18:3] == 16'd0,
		"degenerate word with nonzero fraction")
	`WRMN_ASSERT_NOW(a_done_wait, drsp.done,
		state_q == wrmn_pkg::ST_P1W || state_q == wrmn_pkg::ST_P2W, "stray divider done")
	`WRMN_ASSERT_NOW(a_clear_idle, clearing, !s_tready, "item taken during zeroing pass")
endmodule
`default_nettype wire

[design/wrmn_row_ram.sv]
// row store memory with one write and one registered read port
// runs a zeroing pass over every entry after reset; uses wrmn_pkg
`timescale 1ns / 1ps
`default_nettype none
module wrmn_row_ram (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         we,
	input  wire logic [wrmn_pkg::ADDR_W-1:0]  waddr,
	input  wire logic [15:0]                  wdata,
	input  wire logic                         re,
	input  wire logic [wrmn_pkg::ADDR_W-1:0]  raddr,
	output logic      [15:0]                  rdata,
	output logic                              clearing
);
	logic [15:0] mem [wrmn_pkg::DEPTH];
	logic [wrmn_pkg::ADDR_W:0] clr_q;
	logic                      mwe;
	logic [wrmn_pkg::ADDR_W-1:0] maddr;
	logic [15:0]               mdata;

	assign clearing = !clr_q[wrmn_pkg::ADDR_W];

	// zeroing sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (clearing) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// write port mux
	always_comb begin
		mwe   = clearing || we;
		maddr = clearing ? clr_q[wrmn_pkg::ADDR_W-1:0] : waddr;
		mdata = clearing ? 16'd0 : wdata;
	end

	always_ff @(posedge clk) begin
		if (mwe) begin
			mem[maddr] <= mdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

[design/wrmn_div.sv]
// serial restoring divider giving floor(num * 2^FB / den) for num <= den
// one quotient bit per cycle; uses wrmn_pkg
`timescale 1ns / 1ps
`default_nettype none
module wrmn_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire wrmn_pkg::div_req_t req,
	output wrmn_pkg::div_rsp_t      rsp
);
	logic                          busy_q;
	logic [wrmn_pkg::STEP_W-1:0]   cnt_q;
	logic [wrmn_pkg::TOT_W:0]      r_q;
	logic [wrmn_pkg::TOT_W-1:0]    den_q;
	logic [wrmn_pkg::QW-1:0]       q_q;
	logic [wrmn_pkg::TOT_W:0]      rs;
	logic                          ge;
	logic [wrmn_pkg::QW-1:0]       q_nx;
	logic                          last_step;

	// one shift, compare and subtract step
	always_comb begin
		rs        = (cnt_q == '0) ? r_q : {r_q[wrmn_pkg::TOT_W-1:0], 1'b0};
		ge        = rs >= {1'b0, den_q};
		q_nx      = {q_q[wrmn_pkg::QW-2:0], ge};
		last_step = cnt_q == wrmn_pkg::STEP_W'(wrmn_pkg::STEPS - 1);
		rsp.busy  = busy_q;
		rsp.done  = busy_q && last_step;
		rsp.q     = q_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			busy_q <= !last_step;
			cnt_q  <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			r_q   <= {1'b0, req.num};
			den_q <= req.den;
			q_q   <= '0;
		end else if (busy_q) begin
			r_q <= ge ? (rs - {1'b0, den_q}) : rs;
			q_q <= q_nx;
		end
	end
endmodule
`default_nettype wire

[tb/sv/wrmn_result_checker.sv]
// result checker for the weighted row mix normalizer: watches both streams,
// predicts each result word from a shadow row table and compares field by field
// depends on wrmn_pkg
`timescale 1ns / 1ps
module wrmn_result_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         cfg_we,
	input logic [15:0]  cfg_wdata,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic [103:0] s_tdata,
	input logic [1:0]   s_tuser,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [23:0]  m_tdata,
	input logic         m_tlast,
	output int          fail_count,
	output int          pending_words
);
	import wrmn_pkg::*;

	typedef struct packed {
		logic [2:0]  col;
		logic [15:0] frac;
		logic        degen;
		logic        last;
	} mix_word_t;

	logic [15:0] shadow_rows [0:ROWS-1][0:COLUMNS-1];
	logic [15:0] floor_level;
	mix_word_t   expected_words [$];

	assign pending_words = expected_words.size();

	// floor(num * 2^15 / den) with num <= den
	function automatic logic [63:0] frac_quotient(input logic [63:0] num,
		input logic [63:0] den);
		logic [127:0] wide;
		wide = {64'd0, num} << FRACTION_BITS;
		return 64'(wide / den);
	endfunction

	function automatic logic [15:0] clip16(input logic [63:0] v);
		return (v > 64'd65535) ? 16'hFFFF : v[15:0];
	endfunction

	// update the shadow table and queue the words one accepted item causes
	task automatic predict_item(input logic [1:0] mode, input logic [103:0] d);
		logic [9:0]  trow;
		logic [9:0]  srow;
		logic [2:0]  col;
		logic [63:0] pb;
		logic [63:0] amt;
		logic [63:0] sums [COLUMNS];
		logic [63:0] fr [COLUMNS];
		logic [63:0] total;
		logic [63:0] total2;
		logic        degen;
		logic [15:0] f;
		trow = d[9:0];
		srow = d[19:10];
		col = d[22:20];
		pb = 64'(d[70:39]);
		amt = 64'(d[102:71]);
		total = 0;
		total2 = 0;
		degen = 1'b0;
		if (mode == MODE_WRITE) begin
			shadow_rows[trow][col] = d[38:23];
		end else if (mode == MODE_READ) begin
			expected_words.push_back('{col, shadow_rows[trow][col], 1'b0, 1'b1});
		end else if (mode == MODE_MIX) begin
			for (int j = 0; j < COLUMNS; j++) begin
				sums[j] = 64'(shadow_rows[trow][j]) * pb + 64'(shadow_rows[srow][j]) * amt;
				total += sums[j];
			end
			if (total == 0) begin
				degen = 1'b1;
			end else begin
				for (int j = 0; j < COLUMNS; j++) begin
					fr[j] = frac_quotient(sums[j], total);
					if (fr[j] < 64'(floor_level))
						fr[j] = 0;
					total2 += fr[j];
				end
				if (total2 == 0)
					degen = 1'b1;
				else
					for (int j = 0; j < COLUMNS; j++)
						fr[j] = frac_quotient(fr[j], total2);
			end
			for (int j = 0; j < COLUMNS; j++) begin
				f = degen ? 16'd0 : clip16(fr[j]);
				shadow_rows[trow][j] = f;
				expected_words.push_back('{3'(j), f, degen, j == COLUMNS - 1});
			end
		end
	endtask

	// track config, inputs and outputs
	always @(posedge clk or negedge arst_n) begin
		mix_word_t exp_w;
		if (!arst_n) begin
			for (int r = 0; r < ROWS; r++)
				for (int c = 0; c < COLUMNS; c++)
					shadow_rows[r][c] = '0;
			floor_level <= FLOOR_RESET;
			expected_words.delete();
			fail_count <= 0;
		end else begin
			if (cfg_we)
				floor_level <= cfg_wdata;
			if (s_tvalid && s_tready)
				predict_item(s_tuser, s_tdata);
			if (m_tvalid && m_tready) begin
				if (expected_words.size() == 0) begin
					$error("unexpected result word %h last %b", m_tdata, m_tlast);
					fail_count <= fail_count + 1;
				end else begin
					exp_w = expected_words.pop_front();
					if (m_tdata[2:0] !== exp_w.col || m_tdata[18:3] !== exp_w.frac ||
						m_tdata[19] !== exp_w.degen || m_tlast !== exp_w.last)
						fail_count <= fail_count + 1;
					if (m_tdata[2:0] !== exp_w.col)
						$error("out_column expected %0d actual %0d", exp_w.col, m_tdata[2:0]);
					if (m_tdata[18:3] !== exp_w.frac)
						$error("fraction expected %0d actual %0d", exp_w.frac, m_tdata[18:3]);
					if (m_tdata[19] !== exp_w.degen)
						$error("degenerate expected %0d actual %0d", exp_w.degen, m_tdata[19]);
					if (m_tlast !== exp_w.last)
						$error("last expected %0d actual %0d", exp_w.last, m_tlast);
				end
			end
		end
	end
endmodule

[tb/sv/tb_weighted_row_mix_normalizer_unit.sv]
// testbench top for weighted_row_mix_normalizer_unit: stimulus, idling phases,
// threshold settings, watchdog and verdict
// depends on wrmn_pkg, wrmn_result_checker and the block
`timescale 1ns / 1ps
module tb_weighted_row_mix_normalizer_unit;
	import wrmn_pkg::*;

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic [15:0]  cfg_wdata;
	logic         s_tvalid;
	logic         s_tready;
	logic [103:0] s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [23:0]  m_tdata;
	logic         m_tlast;
	int           fail_count;
	int           pending_words;
	int           send_idle_pct;
	int           recv_stall_pct;
	int           hold_cycles;
	int           quiet_cycles;

	weighted_row_mix_normalizer_unit dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	wrmn_result_checker checker_i (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.fail_count(fail_count), .pending_words(pending_words)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// receiver: random stalls, with an optional long hold-off
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				hold_cycles <= hold_cycles - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// watchdog on cycles with no accepted word (covers the clearing pass)
	initial begin
		quiet_cycles = 0;
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles > 40000) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	// offer one word and hold it until accepted
	task automatic send_word(input logic [1:0] mode, input logic [9:0] trow,
		input logic [9:0] srow, input logic [2:0] col, input logic [15:0] val,
		input logic [31:0] pb, input logic [31:0] amt);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= {1'b0, amt, pb, val, col, srow, trow};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_words != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic set_floor(input logic [15:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly small rows so mixes hit shared content, some weights at extremes
	task automatic random_word();
		logic [1:0]  mode;
		logic [31:0] pb;
		logic [31:0] amt;
		logic [9:0]  trow;
		logic [9:0]  srow;
		mode = $urandom_range(9) < 3 ? MODE_WRITE : ($urandom_range(9) < 3 ? MODE_READ :
			($urandom_range(19) == 0 ? MODE_RSVD : MODE_MIX));
		trow = $urandom_range(3) == 0 ? 10'($urandom) : 10'($urandom_range(7));
		srow = $urandom_range(3) == 0 ? 10'($urandom) : 10'($urandom_range(7));
		pb = $urandom_range(3) == 0 ? ($urandom_range(1) ? 32'hFFFFFFFF : 32'd0) : $urandom;
		amt = $urandom_range(3) == 0 ? ($urandom_range(1) ? 32'hFFFFFFFF : 32'd0) : $urandom;
		send_word(mode, trow, srow, 3'($urandom), $urandom_range(3) == 0 ?
			16'($urandom) : 16'($urandom_range(32768)), pb, amt);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = MODE_WRITE;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, every mode, degenerate rows, same row, last row
		send_word(MODE_MIX, 10'd5, 10'd6, 3'd0, 16'd0, 32'hFFFFFFFF, 32'hFFFFFFFF);
		send_word(MODE_WRITE, 10'd1, 10'd0, 3'd0, 16'd32768, 32'd0, 32'd0);
		send_word(MODE_WRITE, 10'd1, 10'd0, 3'd7, 16'hFFFF, 32'd0, 32'd0);
		send_word(MODE_WRITE, 10'd2, 10'd0, 3'd3, 16'd1, 32'd0, 32'd0);
		send_word(MODE_WRITE, 10'd1023, 10'd0, 3'd4, 16'd12345, 32'd0, 32'd0);
		send_word(MODE_READ, 10'd1, 10'd0, 3'd0, 16'd0, 32'd0, 32'd0);
		send_word(MODE_READ, 10'd1, 10'd0, 3'd7, 16'd0, 32'd0, 32'd0);
		send_word(MODE_READ, 10'd1023, 10'd1023, 3'd4, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
		send_word(MODE_RSVD, 10'd1, 10'd2, 3'd1, 16'd7, 32'd1, 32'd1);
		send_word(MODE_MIX, 10'd1, 10'd2, 3'd0, 16'd0, 32'hFFFFFFFF, 32'hFFFFFFFF);
		send_word(MODE_MIX, 10'd2, 10'd2, 3'd0, 16'd0, 32'd3, 32'd1);
		send_word(MODE_MIX, 10'd1, 10'd2, 3'd0, 16'd0, 32'd0, 32'd0);
		send_word(MODE_WRITE, 10'd3, 10'd0, 3'd2, 16'd30000, 32'd0, 32'd0);
		send_word(MODE_WRITE, 10'd3, 10'd0, 3'd5, 16'd100, 32'd0, 32'd0);
		send_word(MODE_MIX, 10'd3, 10'd1023, 3'd0, 16'd0, 32'd1, 32'd0);
		send_word(MODE_READ, 10'd3, 10'd0, 3'd5, 16'd0, 32'd0, 32'd0);
		wait_drained();

		// random phases with threshold settings including both extremes
		for (int ph = 0; ph < 6; ph++) begin
			set_floor(ph == 0 ? 16'd0 : ph == 1 ? 16'd32768 : ph == 2 ? 16'hFFFF :
				ph == 5 ? FLOOR_RESET : 16'($urandom_range(8000)));
			send_idle_pct = ph % 4 == 1 ? 58 : ph % 4 == 3 ? 34 : 0;
			recv_stall_pct = ph % 4 == 2 ? 58 : ph % 4 == 3 ? 34 : 0;
			if (ph == 4)
				hold_cycles <= 3000;
			for (int i = 0; i < 72; i++)
				random_word();
			wait_drained();
		end

		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
